### src/boundary_precision_recall_counts_macros.svh
// Assertion macros for the boundary precision/recall counter.
`ifndef BOUNDARY_PRECISION_RECALL_COUNTS_MACROS_SVH
`define BOUNDARY_PRECISION_RECALL_COUNTS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bprc_pkg.sv
// Shared types and constants of the boundary precision/recall counter.
package bprc_pkg;

    localparam int DEF_MAX_WIDTH     = 2048;
    localparam int DEF_MAX_HEIGHT    = 2048;
    localparam int DEF_MAX_TOLERANCE = 8;

    localparam int SIZE_W   = 12;
    localparam int TOL_W    = 4;
    localparam int MARGIN_W = 8;
    localparam int PIX_W    = 8;
    localparam int COUNT_W  = 23;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int S_TDATA_W   = 2 * PIX_W;
    localparam int M_TDATA_W   = ((4 * COUNT_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0]  COUNT_LIMIT   = COUNT_W'(4194304);
    localparam logic [SIZE_W-1:0]   RST_WIDTH     = SIZE_W'(640);
    localparam logic [SIZE_W-1:0]   RST_HEIGHT    = SIZE_W'(480);
    localparam logic [TOL_W-1:0]    RST_TOLERANCE = TOL_W'(2);
    localparam logic [MARGIN_W-1:0] RST_MARGIN    = MARGIN_W'(50);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH     = 2'd0,
        CFG_IMAGE_HEIGHT    = 2'd1,
        CFG_MATCH_TOLERANCE = 2'd2,
        CFG_BORDER_MARGIN   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic center_rel;
        logic center_ret;
        logic rel_matched;
        logic ret_matched;
    } t_hits;

endpackage

### src/bprc_window.sv
// Horizontal match window: recent column histories and window hit logic.
module bprc_window #(
    parameter int MAX_TOLERANCE = bprc_pkg::DEF_MAX_TOLERANCE,
    parameter int TW            = $clog2(MAX_TOLERANCE + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_shift,
    input  logic [2*(2*MAX_TOLERANCE+1)-1:0] i_hist,
    input  logic [TW-1:0]                  i_tol,
    output bprc_pkg::t_hits                o_hits
);
    import bprc_pkg::*;

    localparam int HD = 2 * MAX_TOLERANCE + 1;
    localparam int ND = 2 * MAX_TOLERANCE;
    localparam int IW = $clog2(HD);

    logic [2*HD-1:0] r_line [ND];
    logic [2*HD-1:0] cols   [HD];
    logic [TW:0]     win_last;
    logic [HD-1:0]   mask;
    logic [HD-1:0]   rel_bits;
    logic [HD-1:0]   ret_bits;
    logic [IW-1:0]   tol_idx;
    logic            any_rel;
    logic            any_ret;
    logic            c_rel;
    logic            c_ret;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_line[0] <= i_hist;
            for (int j = 1; j < ND; j++) begin
                r_line[j] <= r_line[j-1];
            end
        end
    end

    always_comb begin
        win_last = {i_tol, 1'b0};
        tol_idx  = IW'(i_tol);
        cols[0]  = i_hist;
        for (int j = 1; j < HD; j++) begin
            cols[j] = r_line[j-1];
        end
        for (int k = 0; k < HD; k++) begin
            mask[k] = ((TW+1)'(k) <= win_last);
        end
        any_rel = 1'b0;
        any_ret = 1'b0;
        c_rel   = 1'b0;
        c_ret   = 1'b0;
        rel_bits = '0;
        ret_bits = '0;
        for (int j = 0; j < HD; j++) begin
            if ((TW+1)'(j) <= win_last) begin
                any_rel = any_rel | (|(cols[j][HD-1:0] & mask));
                any_ret = any_ret | (|(cols[j][2*HD-1:HD] & mask));
            end
            if ((TW+1)'(j) == {1'b0, i_tol}) begin
                rel_bits = cols[j][HD-1:0];
                ret_bits = cols[j][2*HD-1:HD];
            end
        end
        c_rel = rel_bits[tol_idx];
        c_ret = ret_bits[tol_idx];
        o_hits.center_rel  = c_rel;
        o_hits.center_ret  = c_ret;
        o_hits.rel_matched = c_rel & any_ret;
        o_hits.ret_matched = c_ret & any_rel;
    end

endmodule

### src/boundary_precision_recall_counts.sv
// Boundary precision/recall counter: top level.
// Throughput: one pixel pair per cycle while no finished result waits on m_axis_tready,
// set by the single read and single write port of the column history memory (read at
// accept, written at retire); the count result is registered when the last pixel retires.
// Reset (synchronous, active low) clears position, counts, output valid and restores
// register defaults; the column history memory is not cleared.
module boundary_precision_recall_counts #(
    parameter int MAX_WIDTH     = bprc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = bprc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_TOLERANCE = bprc_pkg::DEF_MAX_TOLERANCE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // relevant_pixel [7:0], retrieved_pixel [15:8]
    input  logic [bprc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // relevant_count [22:0], relevant_matched_count [45:23],
    // retrieved_count [68:46], retrieved_matched_count [91:69], zero fill
    output logic [bprc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bprc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [bprc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bprc_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int TW  = $clog2(MAX_TOLERANCE + 1);
    localparam int HD  = 2 * MAX_TOLERANCE + 1;
    localparam int M1  = (CW > RW) ? CW : RW;
    localparam int M2  = (M1 > SIZE_W) ? M1 : SIZE_W;
    localparam int KW  = M2 + 2;
    localparam int TCW = (TW > TOL_W) ? TW : TOL_W;

    // configuration
    logic [SIZE_W-1:0]   r_image_width;
    logic [SIZE_W-1:0]   r_image_height;
    logic [TOL_W-1:0]    r_match_tolerance;
    logic [MARGIN_W-1:0] r_border_margin;

    // position
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // pixel stage
    logic          r_s1_valid;
    logic          r_s1_rel;
    logic          r_s1_ret;
    logic [CW-1:0] r_s1_addr;
    logic          r_s1_count;
    logic          r_s1_last;
    logic          r_s1_fwd;

    logic [2*HD-1:0] r_mem [MAX_WIDTH];
    logic [2*HD-1:0] r_rd_data;
    logic [2*HD-1:0] r_last_hist;

    logic [COUNT_W-1:0] r_cnt [4];
    logic [COUNT_W-1:0] n_cnt [4];
    logic [COUNT_W-1:0] r_out [4];
    logic               r_out_valid;

    logic            s_acc;
    logic            retire_ok;
    logic            retire;
    logic [KW-1:0]   w_eff;
    logic [KW-1:0]   h_eff;
    logic [KW-1:0]   cx_k;
    logic [KW-1:0]   cy_k;
    logic [KW-1:0]   m_k;
    logic [KW-1:0]   lo_k;
    logic [TCW-1:0]  tol_full;
    logic [TW-1:0]   tol;
    logic            center_ok;
    logic            last_col;
    logic            last_row;
    logic [2*HD-1:0] old_hist;
    logic [2*HD-1:0] new_hist;
    logic [3:0]      bump;
    t_hits           hits;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c,
                                                   input logic en);
        logic [COUNT_W-1:0] r;
        r = c;
        if (en && (c < COUNT_LIMIT)) begin
            r = c + COUNT_W'(1);
        end
        return r;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width     <= RST_WIDTH;
            r_image_height    <= RST_HEIGHT;
            r_match_tolerance <= RST_TOLERANCE;
            r_border_margin   <= RST_MARGIN;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_IMAGE_WIDTH:     r_image_width     <= i_cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT:    r_image_height    <= i_cfg_data[SIZE_W-1:0];
                CFG_MATCH_TOLERANCE: r_match_tolerance <= i_cfg_data[TOL_W-1:0];
                CFG_BORDER_MARGIN:   r_border_margin   <= i_cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry and the counted-center test
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = KW'(1);
        end else if (KW'(r_image_width) > KW'(MAX_WIDTH)) begin
            w_eff = KW'(MAX_WIDTH);
        end else begin
            w_eff = KW'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_eff = KW'(1);
        end else if (KW'(r_image_height) > KW'(MAX_HEIGHT)) begin
            h_eff = KW'(MAX_HEIGHT);
        end else begin
            h_eff = KW'(r_image_height);
        end
        tol_full = (TCW'(r_match_tolerance) > TCW'(MAX_TOLERANCE)) ?
                   TCW'(MAX_TOLERANCE) : TCW'(r_match_tolerance);
        tol       = tol_full[TW-1:0];
        cx_k      = KW'(r_col);
        cy_k      = KW'(r_row);
        m_k       = KW'(r_border_margin);
        lo_k      = m_k + (KW'(tol) << 1);
        center_ok = (cx_k >= lo_k) && ((cx_k + m_k) < w_eff) &&
                    (cy_k >= lo_k) && ((cy_k + m_k) < h_eff);
        last_col  = (cx_k + KW'(1)) >= w_eff;
        last_row  = (cy_k + KW'(1)) >= h_eff;
    end

    assign retire_ok     = !r_s1_last || !r_out_valid || m_axis_tready;
    assign retire        = r_s1_valid && retire_ok;
    assign s_axis_tready = !r_s1_valid || retire_ok;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_s1_valid <= 1'b1;
                if (!last_col) begin
                    r_col <= r_col + CW'(1);
                end else begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + RW'(1);
                end
            end else if (retire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_rel   <= |s_axis_tdata[PIX_W-1:0];
            r_s1_ret   <= |s_axis_tdata[2*PIX_W-1:PIX_W];
            r_s1_addr  <= r_col;
            r_s1_count <= center_ok;
            r_s1_last  <= last_col && last_row;
            r_s1_fwd   <= retire && (r_s1_addr == r_col);
            r_rd_data  <= r_mem[r_col];
        end
    end

    // column history update; forward the previous write on a same-column read
    always_comb begin
        old_hist = r_s1_fwd ? r_last_hist : r_rd_data;
        new_hist = {old_hist[2*HD-2:HD], r_s1_ret, old_hist[HD-2:0], r_s1_rel};
    end

    always_ff @(posedge i_clk) begin
        if (retire) begin
            r_mem[r_s1_addr] <= new_hist;
            r_last_hist      <= new_hist;
        end
    end

    bprc_window #(
        .MAX_TOLERANCE (MAX_TOLERANCE),
        .TW            (TW)
    ) u_window (
        .i_clk   (i_clk),
        .i_shift (retire),
        .i_hist  (new_hist),
        .i_tol   (tol),
        .o_hits  (hits)
    );

    always_comb begin
        bump[0] = r_s1_count & hits.center_rel;
        bump[1] = r_s1_count & hits.rel_matched;
        bump[2] = r_s1_count & hits.center_ret;
        bump[3] = r_s1_count & hits.ret_matched;
        for (int i = 0; i < 4; i++) begin
            n_cnt[i] = sat_inc(r_cnt[i], bump[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_cnt[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (retire) begin
                for (int i = 0; i < 4; i++) begin
                    r_cnt[i] <= r_s1_last ? '0 : n_cnt[i];
                end
            end
            if (retire && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (retire && r_s1_last) begin
            for (int i = 0; i < 4; i++) begin
                r_out[i] <= n_cnt[i];
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out[3], r_out[2], r_out[1], r_out[0]});

endmodule

### src/bprc_checker.sv
// Port-level checks for the boundary precision/recall counter, bound to the top level.
`include "boundary_precision_recall_counts_macros.svh"

module bprc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic [bprc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready
);
    import bprc_pkg::*;

    logic [COUNT_W-1:0] rel_cnt;
    logic [COUNT_W-1:0] rel_match;
    logic [COUNT_W-1:0] ret_cnt;
    logic [COUNT_W-1:0] ret_match;

    assign rel_cnt   = m_axis_tdata[COUNT_W-1:0];
    assign rel_match = m_axis_tdata[2*COUNT_W-1:COUNT_W];
    assign ret_cnt   = m_axis_tdata[3*COUNT_W-1:2*COUNT_W];
    assign ret_match = m_axis_tdata[4*COUNT_W-1:3*COUNT_W];

    `BPRC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `BPRC_ASSERT_NOW(a_match_le_count, m_axis_tvalid, (rel_match <= rel_cnt) && (ret_match <= ret_cnt), "matched count above its base count")
    `BPRC_ASSERT_NOW(a_count_limit, m_axis_tvalid, (rel_cnt <= COUNT_LIMIT) && (ret_cnt <= COUNT_LIMIT), "count beyond saturation limit")
    `BPRC_ASSERT_NOW(a_no_early_result, $rose(i_rst_n), !m_axis_tvalid, "result offered right after reset")

endmodule

bind boundary_precision_recall_counts bprc_checker u_bprc_checker (.*);

### sim/tb_boundary_precision_recall_counts.sv
// Self-checking testbench: random and directed boundary-map frames, checked against a frame predictor.
module tb_boundary_precision_recall_counts;
    timeunit 1ns;
    timeprecision 1ps;

    import bprc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;

    typedef logic [3:0][COUNT_W-1:0] t_count_quad;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    boundary_precision_recall_counts DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [SIZE_W-1:0]   cfg_width  = RST_WIDTH;
    logic [SIZE_W-1:0]   cfg_height = RST_HEIGHT;
    logic [TOL_W-1:0]    cfg_tol    = RST_TOLERANCE;
    logic [MARGIN_W-1:0] cfg_margin = RST_MARGIN;
    bit [16:0]           rel_hist [DEF_MAX_WIDTH];
    bit [16:0]           ret_hist [DEF_MAX_WIDTH];
    int                  col_pos = 0;
    int                  row_pos = 0;
    t_count_quad         tally = '0;
    t_count_quad         expected_counts [$];

    logic [S_TDATA_W-1:0] pixel_queue [$];
    int    pix_sent = 0;
    int    pix_accepted = 0;
    int    src_gap = 0;
    int    sink_gap = 0;
    bit    throttle = 1'b0;
    int    err_count = 0;
    int    stall_cycles = 0;
    string count_name [4] = '{"relevant_count", "relevant_matched_count",
                              "retrieved_count", "retrieved_matched_count"};

    function automatic int eff_size(logic [SIZE_W-1:0] v, int lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic void bump(int k);
        if (tally[k] < COUNT_LIMIT) tally[k] = tally[k] + 1'b1;
    endfunction

    function automatic void apply_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_IMAGE_WIDTH:     cfg_width  = val;
            CFG_IMAGE_HEIGHT:    cfg_height = val;
            CFG_MATCH_TOLERANCE: cfg_tol    = val[TOL_W-1:0];
            CFG_BORDER_MARGIN:   cfg_margin = val[MARGIN_W-1:0];
            default: ;
        endcase
    endfunction

    // shift the pixel pair into the column history, judge the completed center,
    // and close the frame after its last pixel
    function automatic void score_pixel(logic [PIX_W-1:0] rel_px, logic [PIX_W-1:0] ret_px);
        int          w, h, t, m, cx, cy, ccol;
        logic [16:0] mask;
        logic        rel_near, ret_near;
        w  = eff_size(cfg_width, DEF_MAX_WIDTH);
        h  = eff_size(cfg_height, DEF_MAX_HEIGHT);
        t  = (cfg_tol > DEF_MAX_TOLERANCE) ? DEF_MAX_TOLERANCE : cfg_tol;
        m  = cfg_margin;
        cx = (col_pos >= DEF_MAX_WIDTH) ? DEF_MAX_WIDTH - 1 : col_pos;
        cy = row_pos;
        rel_hist[cx] = {rel_hist[cx][15:0], rel_px != 8'd0};
        ret_hist[cx] = {ret_hist[cx][15:0], ret_px != 8'd0};
        if (cx >= m + 2 * t && cx + m < w && cy >= m + 2 * t && cy + m < h) begin
            ccol = cx - t;
            mask = (17'd1 << (2 * t + 1)) - 17'd1;
            rel_near = 1'b0;
            ret_near = 1'b0;
            for (int c = cx - 2 * t; c <= cx; c++) begin
                if ((ret_hist[c] & mask) != 0) rel_near = 1'b1;
                if ((rel_hist[c] & mask) != 0) ret_near = 1'b1;
            end
            if (rel_hist[ccol][t]) begin
                bump(0);
                if (rel_near) bump(1);
            end
            if (ret_hist[ccol][t]) begin
                bump(2);
                if (ret_near) bump(3);
            end
        end
        if (cx + 1 < w) begin
            col_pos = cx + 1;
        end else begin
            col_pos = 0;
            if (cy + 1 < h) begin
                row_pos = cy + 1;
            end else begin
                row_pos = 0;
                expected_counts.insert(expected_counts.size(), tally);
                tally = '0;
            end
        end
    endfunction

    // valid only when the stream is drained
    function automatic int pixels_left();
        int w, h;
        w = eff_size(cfg_width, DEF_MAX_WIDTH);
        h = eff_size(cfg_height, DEF_MAX_HEIGHT);
        return ((col_pos < w) ? w - col_pos : 1) + ((row_pos + 1 < h) ? (h - 1 - row_pos) * w : 0);
    endfunction

    function automatic int frame_size();
        return eff_size(cfg_width, DEF_MAX_WIDTH) * eff_size(cfg_height, DEF_MAX_HEIGHT);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(int density);
        if ($urandom_range(0, 99) >= density) return 8'd0;
        return (density >= 100) ? 8'hFF : 8'($urandom_range(1, 255));
    endfunction

    function automatic void push_pixels(int n, int density);
        logic [PIX_W-1:0] rel_px, ret_px;
        repeat (n) begin
            rel_px = pick_pixel(density);
            ret_px = pick_pixel(density);
            pixel_queue.insert(pixel_queue.size(), {ret_px, rel_px});
        end
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return SIZE_W'($urandom_range(13, 24));
        return SIZE_W'($urandom_range(1, 12));
    endfunction

    function automatic void flag(string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR: %s", msg);
    endfunction

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // hold the source until every pixel is taken and every result is back
    task automatic settle();
        while (pixel_queue.size() != 0 || pix_accepted != pix_sent || expected_counts.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic setup(int w, int h, int t, int m);
        settle();
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_MATCH_TOLERANCE, CFG_DATA_W'(t));
        write_reg(CFG_BORDER_MARGIN, CFG_DATA_W'(m));
    endtask

    // pixel source
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (pix_accepted == pix_sent) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                s_axis_tdata  <= pixel_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                pix_sent++;
                if (throttle && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 5);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (throttle && $urandom_range(0, 3) == 0) sink_gap = $urandom_range(1, 5);
        end
    end

    // transfer monitor, predictor update and result check
    always @(posedge i_clk) begin
        t_count_quad got, want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) apply_reg(t_cfg_reg'(i_cfg_index), i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) begin
                score_pixel(s_axis_tdata[PIX_W-1:0], s_axis_tdata[2*PIX_W-1:PIX_W]);
                pix_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[4*COUNT_W-1:0];
                if (expected_counts.size() == 0) begin
                    flag($sformatf("count result with no frame pending: %h", got));
                end else begin
                    want = expected_counts.pop_front();
                    for (int k = 0; k < 4; k++)
                        if (got[k] !== want[k])
                            flag($sformatf("%s: expected %0d, got %0d",
                                           count_name[k], want[k], got[k]));
                end
            end
            if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end else if (++stall_cycles >= WATCHDOG_LIMIT) begin
                $display("TIMEOUT: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("boundary_precision_recall_counts verification failed");
                $finish;
            end
        end
    end

    initial begin
        int rand_items, frames, k, n, sel;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        throttle = 1'b1;

        setup(8, 8, 0, 0);       push_pixels(pixels_left(), 0);
        setup(8, 8, 2, 0);       push_pixels(pixels_left(), 100);
        setup(9, 9, 1, 1);       push_pixels(pixels_left(), 40);
        setup(0, 0, 3, 0);       push_pixels(pixels_left(), 100);   // zero size -> 1x1
        setup(20, 20, 15, 0);    push_pixels(pixels_left(), 20);    // tolerance saturates
        setup(6, 6, 8, 255);     push_pixels(pixels_left(), 60);    // nothing counted
        // shrink width, then height, while a frame is in flight
        setup(10, 10, 1, 0);
        push_pixels(47, 50);
        settle();
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(5));
        push_pixels(18, 50);
        settle();
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(4));
        push_pixels(pixels_left(), 50);

        rand_items = 0;
        frames = 0;
        while (rand_items < 300 || frames < 8) begin
            settle();
            throttle = (rand_items < 200) && ($urandom_range(0, 3) != 0);
            sel = $urandom_range(1, 15);
            if (sel[0]) write_reg(CFG_IMAGE_WIDTH, pick_size());
            if (sel[1]) write_reg(CFG_IMAGE_HEIGHT, pick_size());
            if (sel[2])
                write_reg(CFG_MATCH_TOLERANCE,
                          {8'($urandom_range(0, 255)),
                           ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                       : 4'($urandom_range(0, 3))});
            if (sel[3]) begin
                k = $urandom_range(0, 9);
                write_reg(CFG_BORDER_MARGIN,
                          {4'($urandom_range(0, 15)),
                           (k == 0) ? 8'($urandom_range(0, 255)) :
                           (k < 3)  ? 8'($urandom_range(3, 8)) : 8'($urandom_range(0, 2))});
            end
            k = $urandom_range(1, 2);
            n = pixels_left() + (k - 1) * frame_size();
            push_pixels(n, $urandom_range(5, 95));
            rand_items += n;
            frames += k;
        end

        settle();
        if (err_count == 0) begin
            $display("boundary_precision_recall_counts verification clean");
        end else begin
            $display("boundary_precision_recall_counts verification failed");
        end
        $finish;
    end

endmodule
